>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define SAWL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SAWL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sawl_pkg.sv
// Types and codes for the suffix array and prefix table block.
`timescale 1ns / 1ps
package sawl_pkg;

   localparam int PREFIX_W = 12;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_NOT_READY = 2'd3;

   localparam logic [PREFIX_W-1:0] PREFIX_NONE = '1;

   typedef struct packed {
      logic       command;
      logic [7:0] symbol;
      logic       last;
      logic [9:0] rank;
   } req_type;

   typedef struct packed {
      logic [9:0]                 position;
      logic signed [PREFIX_W-1:0] prefix_length;
      logic [1:0]                 status;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic pend_valid;
   } core_status_type;

endpackage

>>> rtl/sawl_addmod.sv
// Shared modular adder: (a + b) mod m for a < m and b <= m.
`timescale 1ns / 1ps
module sawl_addmod #(
   parameter int AW = 10,
   parameter int CW = 11
) (
   input  logic [AW-1:0] a,
   input  logic [CW-1:0] b,
   input  logic [CW-1:0] m,
   output logic [AW-1:0] y
);

   logic [CW:0] sum;
   logic [CW:0] wrap;

   always_comb begin
      sum  = (CW+1)'(a) + (CW+1)'(b);
      wrap = sum - (CW+1)'(m);
      y    = (sum >= (CW+1)'(m)) ? AW'(wrap) : AW'(sum);
   end

endmodule

>>> rtl/sawl_core.sv
// Text, sort and prefix memories with the sequencer that runs the sort and fills the prefix table.
`timescale 1ns / 1ps
module sawl_core import sawl_pkg::*; #(
   parameter int MAX_LEN  = 1024,
   parameter int ALPHABET = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_accept,
   input  req_type         req_word,
   output core_status_type status,
   output rsp_type         pend_rsp
);

   localparam int AW      = $clog2(MAX_LEN);
   localparam int CW      = $clog2(MAX_LEN + 1);
   localparam int SW      = CW + 1;
   localparam int BUCKETS = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
   localparam int BW      = $clog2(BUCKETS);
   localparam int IW      = $clog2(BUCKETS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CLR  = 3'd1;
   localparam logic [2:0] S_CNT  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_PLC  = 3'd4;
   localparam logic [2:0] S_CLS  = 3'd5;
   localparam logic [2:0] S_RNK  = 3'd6;
   localparam logic [2:0] S_KAS  = 3'd7;

   // memories
   logic [7:0]          text_mem [MAX_LEN];
   logic [AW-1:0]       ord0_mem [MAX_LEN];
   logic [AW-1:0]       ord1_mem [MAX_LEN];
   logic [AW-1:0]       cls0_mem [MAX_LEN];
   logic [AW-1:0]       cls1_mem [MAX_LEN];
   logic [CW-1:0]       bkt_mem  [BUCKETS];
   logic [AW-1:0]       rop_mem  [MAX_LEN];
   logic [PREFIX_W-1:0] pre_mem  [MAX_LEN];

   logic [7:0]          text_qa, text_qb, text_wd;
   logic [AW-1:0]       text_raa, text_rab, text_wa;
   logic                text_we;
   logic [AW-1:0]       ord_ra, ord_wa, ord_wd, ord_q0, ord_q1, ord_q;
   logic                ord_we;
   logic [AW-1:0]       cls_ra1, cls_ra2, cls_wa, cls_wd;
   logic [AW-1:0]       c0_q1, c0_q2, c1_q1, c1_q2, cls_q1, cls_q2;
   logic                cls_we;
   logic [BW-1:0]       bkt_ra, bkt_wa;
   logic [CW-1:0]       bkt_wd, bkt_q;
   logic                bkt_we;
   logic [AW-1:0]       rop_ra, rop_wa, rop_wd, rop_q;
   logic                rop_we;
   logic [AW-1:0]       pre_ra, pre_wa;
   logic [PREFIX_W-1:0] pre_wd, pre_q;
   logic                pre_we;

   // sequencer state
   logic [2:0]    st_ff, st_in;
   logic [2:0]    ph_ff, ph_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] len_ff, len_in;
   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] nms_ff, nms_in;
   logic          first_ff, first_in;
   logic          ob_ff, ob_in;
   logic          cb_ff, cb_in;
   logic          ready_ff, ready_in;
   logic [AW-1:0] b_ff, b_in;
   logic [BW-1:0] key_ff, key_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic [AW-1:0] c_ff, c_in;
   logic [BW-1:0] prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic [AW-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [CW-1:0] k_ff, k_in;
   logic [AW-1:0] r_ff, r_in, j_ff, j_in, far_ff, far_in;
   logic          pend_ff, pend_in;
   logic          pend_cmd_ff, pend_cmd_in;
   logic [1:0]    pend_stat_ff, pend_stat_in;

   logic [AW-1:0] am_y;
   logic [CW-1:0] am_b;
   logic [IW-1:0] lim;
   logic          at_end;
   logic          at_end_n;
   logic [CW-1:0] eff_len;
   logic [7:0]    sym;
   logic [BW-1:0] k1, k2;
   logic [AW-1:0] cnew;
   logic [SW-1:0] nstep;
   logic [SW-1:0] reach;

   sawl_addmod #(.AW(AW), .CW(CW)) u_addmod (
      .a(ord_q),
      .b(am_b),
      .m(len_ff),
      .y(am_y)
   );

   assign ord_q  = ob_ff ? ord_q1 : ord_q0;
   assign cls_q1 = cb_ff ? c1_q1 : c0_q1;
   assign cls_q2 = cb_ff ? c1_q2 : c0_q2;
   assign am_b   = (st_ff == S_CLS) ? CW'(step_ff) : nms_ff;
   assign lim    = (first_ff && (st_ff == S_CLR || st_ff == S_SUM)) ?
                   IW'(ALPHABET) : IW'(len_ff);
   assign at_end   = (idx_ff == lim - IW'(1));
   assign at_end_n = (idx_ff == IW'(len_ff) - IW'(1));
   assign eff_len  = ready_ff ? '0 : len_ff;
   assign sym      = ({1'b0, req_word.symbol} >= 9'(ALPHABET)) ?
                     8'(ALPHABET - 1) : req_word.symbol;
   assign reach    = SW'(far_ff) + SW'(k_ff);

   always_comb begin
      st_in        = st_ff;
      ph_in        = ph_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      nms_in       = nms_ff;
      first_in     = first_ff;
      ob_in        = ob_ff;
      cb_in        = cb_ff;
      ready_in     = ready_ff;
      b_in         = b_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      c_in         = c_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      j_in         = j_ff;
      far_in       = far_ff;
      pend_in      = req_accept;
      pend_cmd_in  = pend_cmd_ff;
      pend_stat_in = pend_stat_ff;
      k1           = '0;
      k2           = '0;
      cnew         = '0;
      nstep        = '0;

      text_we  = 1'b0;
      text_wa  = eff_len[AW-1:0];
      text_wd  = sym;
      text_raa = b_ff;
      text_rab = j_ff;
      ord_ra   = idx_ff[AW-1:0];
      ord_we   = 1'b0;
      ord_wa   = bkt_q[AW-1:0];
      ord_wd   = b_ff;
      cls_ra1  = b_ff;
      cls_ra2  = q2_ff;
      cls_we   = 1'b0;
      cls_wa   = q1_ff;
      cls_wd   = '0;
      bkt_ra   = idx_ff[BW-1:0];
      bkt_we   = 1'b0;
      bkt_wa   = idx_ff[BW-1:0];
      bkt_wd   = '0;
      rop_ra   = idx_ff[AW-1:0];
      rop_we   = 1'b0;
      rop_wa   = ord_q;
      rop_wd   = idx_ff[AW-1:0];
      pre_ra   = AW'(req_word.rank);
      pre_we   = 1'b0;
      pre_wa   = r_ff;
      pre_wd   = PREFIX_W'(k_ff);

      if (req_accept) begin
         pend_cmd_in = req_word.command;
         if (req_word.command == CMD_LOAD) begin
            ready_in = 1'b0;
            if (eff_len < CW'(MAX_LEN)) begin
               text_we      = 1'b1;
               len_in       = eff_len + CW'(1);
               pend_stat_in = ST_OK;
            end else begin
               len_in       = eff_len;
               pend_stat_in = ST_OVERFLOW;
            end
            if (req_word.last) begin
               st_in    = S_CLR;
               ph_in    = '0;
               idx_in   = '0;
               first_in = 1'b1;
               step_in  = SW'(1);
            end
         end else if (!ready_ff) begin
            pend_stat_in = ST_NOT_READY;
         end else if (32'(req_word.rank) >= 32'(len_ff)) begin
            pend_stat_in = ST_RANGE;
         end else begin
            pend_stat_in = ST_OK;
         end
      end

      unique case (st_ff)
         S_IDLE: begin
            ord_ra = AW'(req_word.rank);
         end
         S_CLR: begin
            bkt_we = 1'b1;
            bkt_wd = '0;
            if (at_end) begin
               st_in  = S_CNT;
               idx_in = '0;
               ph_in  = '0;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_CNT, S_PLC: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  b_in  = first_ff ? idx_ff[AW-1:0] : am_y;
                  ph_in = 3'd2;
               end
               3'd2: ph_in = 3'd3;
               3'd3: begin
                  key_in = first_ff ? BW'(text_qa) : BW'(cls_q1);
                  bkt_ra = key_in;
                  ph_in  = 3'd4;
               end
               default: begin
                  bkt_we = 1'b1;
                  bkt_wa = key_ff;
                  bkt_wd = bkt_q + CW'(1);
                  ord_we = (st_ff == S_PLC);
                  ph_in  = 3'd0;
                  if (at_end_n) begin
                     idx_in = '0;
                     sum_in = '0;
                     if (st_ff == S_CNT) begin
                        st_in = S_SUM;
                     end else begin
                        st_in = S_CLS;
                        ob_in = ~ob_ff;
                     end
                  end else begin
                     idx_in = idx_ff + IW'(1);
                  end
               end
            endcase
         end
         S_SUM: begin
            if (ph_ff == 3'd0) begin
               ph_in = 3'd1;
            end else begin
               bkt_we = 1'b1;
               bkt_wd = sum_ff;
               sum_in = sum_ff + bkt_q;
               ph_in  = 3'd0;
               if (at_end) begin
                  st_in  = S_PLC;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         S_CLS: begin
            text_raa = q1_ff;
            cls_ra1  = q1_ff;
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  q1_in = ord_q;
                  q2_in = am_y;
                  ph_in = 3'd2;
               end
               3'd2: ph_in = 3'd3;
               default: begin
                  k1   = first_ff ? BW'(text_qa) : BW'(cls_q1);
                  k2   = first_ff ? '0 : BW'(cls_q2);
                  cnew = (idx_ff == '0) ? '0 :
                         c_ff + AW'((k1 != prev1_ff) || (k2 != prev2_ff));
                  cls_we   = 1'b1;
                  cls_wd   = cnew;
                  c_in     = cnew;
                  prev1_in = k1;
                  prev2_in = k2;
                  ph_in    = 3'd0;
                  if (at_end_n) begin
                     nstep    = first_ff ? step_ff : (step_ff << 1);
                     step_in  = nstep;
                     first_in = 1'b0;
                     cb_in    = ~cb_ff;
                     idx_in   = '0;
                     if (nstep <= SW'(len_ff)) begin
                        st_in  = S_CLR;
                        nms_in = CW'(SW'(len_ff) - nstep);
                     end else begin
                        st_in = S_RNK;
                     end
                  end else begin
                     idx_in = idx_ff + IW'(1);
                  end
               end
            endcase
         end
         S_RNK: begin
            if (ph_ff == 3'd0) begin
               ph_in = 3'd1;
            end else begin
               rop_we = 1'b1;
               ph_in  = 3'd0;
               if (at_end_n) begin
                  st_in  = S_KAS;
                  idx_in = '0;
                  k_in   = '0;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         S_KAS: begin
            case (ph_ff)
               3'd0: begin
                  if (k_ff != '0) k_in = k_ff - CW'(1);
                  ph_in = 3'd1;
               end
               3'd1: begin
                  r_in   = rop_q;
                  ord_ra = rop_q + AW'(1);
                  if (CW'(rop_q) == len_ff - CW'(1)) begin
                     pre_we = 1'b1;
                     pre_wa = rop_q;
                     pre_wd = PREFIX_NONE;
                     k_in   = '0;
                     ph_in  = 3'd5;
                  end else begin
                     ph_in = 3'd2;
                  end
               end
               3'd2: begin
                  j_in   = ord_q;
                  far_in = (idx_ff[AW-1:0] > ord_q) ? idx_ff[AW-1:0] : ord_q;
                  ph_in  = 3'd3;
               end
               3'd3: begin
                  text_raa = idx_ff[AW-1:0] + k_ff[AW-1:0];
                  text_rab = j_ff + k_ff[AW-1:0];
                  if (reach < SW'(len_ff)) begin
                     ph_in = 3'd4;
                  end else begin
                     pre_we = 1'b1;
                     ph_in  = 3'd5;
                  end
               end
               3'd4: begin
                  if (text_qa == text_qb) begin
                     k_in  = k_ff + CW'(1);
                     ph_in = 3'd3;
                  end else begin
                     pre_we = 1'b1;
                     ph_in  = 3'd5;
                  end
               end
               default: begin
                  ph_in = 3'd0;
                  if (at_end_n) begin
                     st_in    = S_IDLE;
                     ready_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + IW'(1);
                  end
               end
            endcase
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      pend_rsp.status        = pend_stat_ff;
      pend_rsp.position      = '0;
      pend_rsp.prefix_length = '0;
      if (pend_cmd_ff == CMD_READ && pend_stat_ff == ST_OK) begin
         pend_rsp.position      = 10'(ord_q);
         pend_rsp.prefix_length = pre_q;
      end
   end

   assign status.busy       = (st_ff != S_IDLE);
   assign status.pend_valid = pend_ff;

   always_ff @(posedge clock) begin
      if (text_we) text_mem[text_wa] <= text_wd;
      text_qa <= text_mem[text_raa];
      text_qb <= text_mem[text_rab];
   end

   always_ff @(posedge clock) begin
      if (ord_we && ob_ff) ord0_mem[ord_wa] <= ord_wd;
      ord_q0 <= ord0_mem[ord_ra];
   end

   always_ff @(posedge clock) begin
      if (ord_we && !ob_ff) ord1_mem[ord_wa] <= ord_wd;
      ord_q1 <= ord1_mem[ord_ra];
   end

   always_ff @(posedge clock) begin
      if (cls_we && cb_ff) cls0_mem[cls_wa] <= cls_wd;
      c0_q1 <= cls0_mem[cls_ra1];
      c0_q2 <= cls0_mem[cls_ra2];
   end

   always_ff @(posedge clock) begin
      if (cls_we && !cb_ff) cls1_mem[cls_wa] <= cls_wd;
      c1_q1 <= cls1_mem[cls_ra1];
      c1_q2 <= cls1_mem[cls_ra2];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
      bkt_q <= bkt_mem[bkt_ra];
   end

   always_ff @(posedge clock) begin
      if (rop_we) rop_mem[rop_wa] <= rop_wd;
      rop_q <= rop_mem[rop_ra];
   end

   always_ff @(posedge clock) begin
      if (pre_we) pre_mem[pre_wa] <= pre_wd;
      pre_q <= pre_mem[pre_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         ph_ff    <= '0;
         len_ff   <= '0;
         ready_ff <= 1'b0;
         first_ff <= 1'b0;
         ob_ff    <= 1'b0;
         cb_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         ph_ff    <= ph_in;
         len_ff   <= len_in;
         ready_ff <= ready_in;
         first_ff <= first_in;
         ob_ff    <= ob_in;
         cb_ff    <= cb_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      nms_ff       <= nms_in;
      b_ff         <= b_in;
      key_ff       <= key_in;
      sum_ff       <= sum_in;
      c_ff         <= c_in;
      prev1_ff     <= prev1_in;
      prev2_ff     <= prev2_in;
      q1_ff        <= q1_in;
      q2_ff        <= q2_in;
      k_ff         <= k_in;
      r_ff         <= r_in;
      j_ff         <= j_in;
      far_ff       <= far_in;
      pend_cmd_ff  <= pend_cmd_in;
      pend_stat_ff <= pend_stat_in;
   end

endmodule

>>> rtl/suffix_array_with_lcp_top.sv
// Suffix array with common prefix table: top level with request and response ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Loads append one symbol each up to MAX_LEN; a load marked last then sorts all cyclic shifts by prefix
// doubling with counting sort and fills the common prefix table, during which req_stall
// stays high. A load or read word gives its response through the core's pending register
// and then the response register, and no new word is taken while one is still pending or
// a response held by rsp_stall blocks the output. The sort runs through one shared modular
// adder and single-port-write memories; each pass clears the buckets, counts the keys, forms
// prefix sums, places the shifts and reclasses them, the clear and the sums covering ALPHABET
// buckets on the first pass and n after; the rank table and then the prefix table follow.
module suffix_array_with_lcp_top import sawl_pkg::*; #(
   parameter int MAX_LEN  = 1024,
   parameter int ALPHABET = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   core_status_type core_stat;
   rsp_type         pend_rsp;
   logic            req_accept;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   assign req_stall  = core_stat.busy | core_stat.pend_valid | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;

   sawl_core #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_core (
      .clock(clock),
      .reset(reset),
      .req_accept(req_accept),
      .req_word(req_data),
      .status(core_stat),
      .pend_rsp(pend_rsp)
   );

   assign rsp_valid_in = core_stat.pend_valid | (rsp_valid_ff & rsp_stall);
   assign rsp_data_in  = core_stat.pend_valid ? pend_rsp : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SAWL_ASSERT(a_accept_pends, clock, reset, req_accept |=> core_stat.pend_valid, "not pending")
   `SAWL_ASSERT(a_pend_lands, clock, reset, core_stat.pend_valid |=> rsp_valid_ff, "word lost")
   `SAWL_ASSERT(a_pend_free, clock, reset, core_stat.pend_valid |-> !rsp_valid_ff, "rsp occupied")

endmodule

>>> dv/suffix_array_with_lcp_top_tb.sv
// Testbench for the suffix array and common prefix table block, with a self-checking predictor.
`timescale 1ns / 1ps
module suffix_array_with_lcp_top_tb;
   import sawl_pkg::*;

   localparam int MAX_LEN = 1024;
   localparam int ALPHABET = 256;
   localparam int CYCLE_LIMIT = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   suffix_array_with_lcp_top #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   byte unsigned text_mem[MAX_LEN];
   int text_len = 0;
   bit sorted_ok = 0;
   int shift_order[MAX_LEN];
   int shift_class[MAX_LEN];
   int next_class[MAX_LEN];
   int resorted[MAX_LEN];
   int bucket_cnt[MAX_LEN];
   int bucket_pos[MAX_LEN];
   int rank_at[MAX_LEN];
   int lcp_at[MAX_LEN];

   req_type pending[$];
   rsp_type owed_answers[$];
   int words_sent = 0;
   int words_checked = 0;
   int errors = 0;
   int texts_built = 0;
   int cycles = 0;
   int gap = 0;
   int rsp_gap = 0;
   int hold_left = 0;
   bit held = 0;

   function automatic void sort_cyclic_shifts(int n);
      int i, step, b, p, q, p2, q2;
      bit differ;
      for (i = 0; i < MAX_LEN; i++) bucket_cnt[i] = 0;
      for (i = 0; i < n; i++) begin
         shift_class[i] = text_mem[i];
         bucket_cnt[text_mem[i]]++;
      end
      bucket_pos[0] = 0;
      for (i = 1; i < ALPHABET; i++) bucket_pos[i] = bucket_pos[i-1] + bucket_cnt[i-1];
      for (i = 0; i < n; i++) begin
         shift_order[bucket_pos[shift_class[i]]] = i;
         bucket_pos[shift_class[i]]++;
      end
      shift_class[shift_order[0]] = 0;
      for (i = 1; i < n; i++) begin
         p = shift_order[i-1];
         q = shift_order[i];
         shift_class[q] = shift_class[p] + (text_mem[p] != text_mem[q]);
      end
      for (step = 1; step <= n; step *= 2) begin
         for (i = 0; i < MAX_LEN; i++) bucket_cnt[i] = 0;
         for (i = 0; i < n; i++) bucket_cnt[shift_class[(shift_order[i] + n - step) % n]]++;
         bucket_pos[0] = 0;
         for (i = 1; i < n; i++) bucket_pos[i] = bucket_pos[i-1] + bucket_cnt[i-1];
         for (i = 0; i < n; i++) begin
            b = (shift_order[i] + n - step) % n;
            resorted[bucket_pos[shift_class[b]]] = b;
            bucket_pos[shift_class[b]]++;
         end
         for (i = 0; i < n; i++) shift_order[i] = resorted[i];
         next_class[shift_order[0]] = 0;
         for (i = 1; i < n; i++) begin
            p = shift_order[i-1];
            q = shift_order[i];
            p2 = (p + step) % n;
            q2 = (q + step) % n;
            differ = shift_class[p] != shift_class[q] || shift_class[p2] != shift_class[q2];
            next_class[q] = next_class[p] + differ;
         end
         for (i = 0; i < n; i++) shift_class[i] = next_class[i];
      end
   endfunction

   function automatic void fill_lcp(int n);
      int i, j, k, far;
      k = 0;
      for (i = 0; i < n; i++) rank_at[shift_order[i]] = i;
      for (i = 0; i < n; i++) begin
         if (k > 0) k--;
         if (rank_at[i] == n - 1) begin
            lcp_at[n-1] = -1;
            k = 0;
         end else begin
            j = shift_order[rank_at[i] + 1];
            far = (i > j) ? i : j;
            while (far + k < n && text_mem[i+k] == text_mem[j+k]) k++;
            lcp_at[rank_at[i]] = k;
         end
      end
   endfunction

   function automatic rsp_type answer_word(req_type w);
      rsp_type r;
      int sym;
      r = '0;
      r.status = ST_OK;
      if (w.command == CMD_LOAD) begin
         if (sorted_ok) begin
            sorted_ok = 0;
            text_len = 0;
         end
         sym = (int'(w.symbol) >= ALPHABET) ? ALPHABET - 1 : int'(w.symbol);
         if (text_len < MAX_LEN) begin
            text_mem[text_len] = 8'(sym);
            text_len++;
         end else begin
            r.status = ST_OVERFLOW;
         end
         if (w.last) begin
            sort_cyclic_shifts(text_len);
            fill_lcp(text_len);
            sorted_ok = 1;
            texts_built++;
         end
      end else if (!sorted_ok) begin
         r.status = ST_NOT_READY;
      end else if (w.rank >= text_len) begin
         r.status = ST_RANGE;
      end else begin
         r.position = 10'(shift_order[w.rank]);
         r.prefix_length = PREFIX_W'(lcp_at[w.rank]);
      end
      return r;
   endfunction

   function automatic void push_load(int sym, bit fin);
      req_type w;
      w = '0;
      w.command = CMD_LOAD;
      w.symbol = 8'(sym);
      w.last = fin;
      w.rank = 10'($urandom);
      pending = {pending, w};
   endfunction

   function automatic void push_read(int rk);
      req_type w;
      w = '0;
      w.command = CMD_READ;
      w.symbol = 8'($urandom);
      w.last = 1'($urandom);
      w.rank = 10'(rk);
      pending = {pending, w};
   endfunction

   // kind 0: any byte, 1: two letters, 2: one letter
   function automatic void add_text(int len, int kind);
      int i, reads;
      for (i = 0; i < len; i++) begin
         if (kind == 0) push_load($urandom_range(0, 255), i == len - 1);
         else if (kind == 1) push_load(8'h61 + $urandom_range(0, 1), i == len - 1);
         else push_load(8'h7a, i == len - 1);
         if (i < len - 1 && $urandom_range(0, 19) == 0) push_read($urandom_range(0, 1023));
      end
      reads = $urandom_range(1, ((len < 48) ? len : 48) + 2);
      for (i = 0; i < reads; i++) begin
         if ($urandom_range(0, 9) == 0) push_read($urandom_range(0, 1023));
         else push_read($urandom_range(0, len - 1));
      end
   endfunction

   initial begin
      int t;
      push_read(0);
      push_load(8'hff, 1);
      push_read(0);
      push_read(1);
      push_read(1023);
      push_load(8'h41, 0);
      push_load(8'h41, 0);
      push_load(8'h41, 1);
      push_read(0);
      push_read(1);
      push_read(2);
      push_load(8'h00, 0);
      push_load(8'hff, 0);
      push_load(8'h00, 1);
      push_read(0);
      push_read(1);
      push_read(2);
      push_read(3);
      push_load(8'h42, 0);
      push_read(0);
      push_load(8'h41, 1);
      push_read(1);
      t = 0;
      while (pending.size() < 1600) begin
         if (t == 8) add_text(MAX_LEN + 6, 1);
         else add_text($urandom_range(1, 48), $urandom_range(0, 2));
         t++;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            owed_answers = {owed_answers, answer_word(req_data)};
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() > 200 && $urandom_range(0, 15) == 0) begin
               gap <= $urandom_range(1, 13) - 1;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!held && words_sent >= 150) begin
         hold_left <= 400;
         held <= 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_answers.size() == 0) begin
               if (errors < 10) $display("unexpected response %p", rsp_data);
               errors++;
            end else begin
               e = owed_answers.pop_front();
               words_checked++;
               if (rsp_data.position !== e.position ||
                   rsp_data.prefix_length !== e.prefix_length ||
                   rsp_data.status !== e.status) begin
                  if (errors < 10)
                     $display({"mismatch word %0d: expected pos %0d lcp %0d st %0d,",
                               " got pos %0d lcp %0d st %0d"},
                              words_checked, e.position, e.prefix_length, e.status,
                              rsp_data.position, rsp_data.prefix_length, rsp_data.status);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (pending.size() > 200 && $urandom_range(0, 11) == 0) begin
            rsp_gap <= $urandom_range(1, 13) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending.size() > 0 || req_valid) @(posedge clock);
      while (owed_answers.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("run: %0d words sent, %0d responses checked, %0d texts sorted, %0d errors",
               words_sent, words_checked, texts_built, errors);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sawl_pkg.sv
rtl/sawl_addmod.sv
rtl/sawl_core.sv
rtl/suffix_array_with_lcp_top.sv
dv/suffix_array_with_lcp_top_tb.sv
